FILE: rtl/core/motor_command_frame_encoder_macros.svh
// assertion helpers shared by the encoder modules
// both expect clk and rst_n in the scope where they are used
`ifndef MOTOR_COMMAND_FRAME_ENCODER_MACROS_SVH
`define MOTOR_COMMAND_FRAME_ENCODER_MACROS_SVH

// same-cycle implication
`define MCFE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mcfe_pkg.sv
package mcfe_pkg;

    localparam int unsigned CODE_BITS = 16;
    localparam longint unsigned CODE_MAX = (64'd1 << CODE_BITS) - 64'd1;

    localparam int unsigned Q_W        = 32;
    localparam int unsigned SLOT_W     = 16;
    localparam int unsigned MOTOR_ID_W = 8;
    localparam int unsigned CMD_W      = 5;
    localparam int unsigned ID_W       = 29;
    localparam int unsigned PAYLOAD_W  = 64;
    localparam int unsigned IN_TDATA_W  = 168;
    localparam int unsigned OUT_TDATA_W = 96;

    localparam logic [CMD_W-1:0] CMD_TYPE_RESET = 5'd1;

    // offset from the lower bound; every span is below 2^25
    localparam int unsigned D_W = 25;
    localparam int unsigned RECIP_SHIFT = 26;
    localparam int unsigned R_W = CODE_BITS + 9;
    localparam int unsigned PROD_W = D_W + R_W;
    localparam int unsigned N_W = D_W + CODE_BITS;

    // range bounds in Q16.16
    localparam logic signed [Q_W-1:0] Q_ANGLE  = 32'sd823788;
    localparam logic signed [Q_W-1:0] Q_VEL_M0 = 32'sd2883584;
    localparam logic signed [Q_W-1:0] Q_VEL_M1 = 32'sd3276800;
    localparam logic signed [Q_W-1:0] Q_TRQ_M0 = 32'sd1114112;
    localparam logic signed [Q_W-1:0] Q_TRQ_M1 = 32'sd360448;
    localparam logic signed [Q_W-1:0] Q_KP_MAX = 32'sd32768000;
    localparam logic signed [Q_W-1:0] Q_KD_MAX = 32'sd327680;

    localparam longint unsigned SPAN_ANG    = 64'd1647576;
    localparam longint unsigned SPAN_VEL_M0 = 64'd5767168;
    localparam longint unsigned SPAN_VEL_M1 = 64'd6553600;
    localparam longint unsigned SPAN_TRQ_M0 = 64'd2228224;
    localparam longint unsigned SPAN_TRQ_M1 = 64'd720896;
    localparam longint unsigned SPAN_KP     = 64'd32768000;
    localparam longint unsigned SPAN_KD     = 64'd327680;

    // floor(2^RECIP_SHIFT * CODE_MAX / span): underestimates the code by at most one
    localparam longint unsigned RSCALE = (64'd1 << RECIP_SHIFT) * CODE_MAX;
    localparam logic [R_W-1:0] RCP_ANG    = R_W'(RSCALE / SPAN_ANG);
    localparam logic [R_W-1:0] RCP_VEL_M0 = R_W'(RSCALE / SPAN_VEL_M0);
    localparam logic [R_W-1:0] RCP_VEL_M1 = R_W'(RSCALE / SPAN_VEL_M1);
    localparam logic [R_W-1:0] RCP_TRQ_M0 = R_W'(RSCALE / SPAN_TRQ_M0);
    localparam logic [R_W-1:0] RCP_TRQ_M1 = R_W'(RSCALE / SPAN_TRQ_M1);
    localparam logic [R_W-1:0] RCP_KP     = R_W'(RSCALE / SPAN_KP);
    localparam logic [R_W-1:0] RCP_KD     = R_W'(RSCALE / SPAN_KD);

    typedef enum logic [2:0] {
        FLD_ANGLE,
        FLD_VELOCITY,
        FLD_TORQUE,
        FLD_STIFFNESS,
        FLD_DAMPING
    } field_t;

    typedef struct packed {
        logic signed [Q_W-1:0] lo;
        logic signed [Q_W-1:0] hi;
        logic [D_W-1:0]        span;
        logic [R_W-1:0]        recip;
    } range_t;

    typedef struct packed {
        logic s0;
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    function automatic range_t field_range(field_t field, logic model);
        range_t r;
        case (field)
            FLD_VELOCITY:
            begin
                r.hi    = model ? Q_VEL_M1 : Q_VEL_M0;
                r.lo    = -r.hi;
                r.span  = model ? D_W'(SPAN_VEL_M1) : D_W'(SPAN_VEL_M0);
                r.recip = model ? RCP_VEL_M1 : RCP_VEL_M0;
            end
            FLD_TORQUE:
            begin
                r.hi    = model ? Q_TRQ_M1 : Q_TRQ_M0;
                r.lo    = -r.hi;
                r.span  = model ? D_W'(SPAN_TRQ_M1) : D_W'(SPAN_TRQ_M0);
                r.recip = model ? RCP_TRQ_M1 : RCP_TRQ_M0;
            end
            FLD_STIFFNESS:
            begin
                r.hi    = Q_KP_MAX;
                r.lo    = '0;
                r.span  = D_W'(SPAN_KP);
                r.recip = RCP_KP;
            end
            FLD_DAMPING:
            begin
                r.hi    = Q_KD_MAX;
                r.lo    = '0;
                r.span  = D_W'(SPAN_KD);
                r.recip = RCP_KD;
            end
            default:
            begin
                r.hi    = Q_ANGLE;
                r.lo    = -Q_ANGLE;
                r.span  = D_W'(SPAN_ANG);
                r.recip = RCP_ANG;
            end
        endcase
        return r;
    endfunction

    // narrow codes sit in the low bits of their 16-bit slot
    function automatic logic [SLOT_W-1:0] slot16(logic [CODE_BITS-1:0] code);
        return SLOT_W'(code);
    endfunction

endpackage

FILE: rtl/core/mcfe_pipe_ctrl.sv
`include "motor_command_frame_encoder_macros.svh"

module mcfe_pipe_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output mcfe_pkg::stage_en_t en
);

    logic [3:0] valid_reg;
    logic [3:0] valid_next;
    logic [3:0] rdy;

    // a stage takes a beat when it is empty or its content moves on
    always_comb
    begin
        rdy[3] = !valid_reg[3] || out_ready;
        rdy[2] = !valid_reg[2] || rdy[3];
        rdy[1] = !valid_reg[1] || rdy[2];
        rdy[0] = !valid_reg[0] || rdy[1];
    end

    always_comb
    begin
        en.s0 = rdy[0] && in_valid;
        en.s1 = rdy[1] && valid_reg[0];
        en.s2 = rdy[2] && valid_reg[1];
        en.s3 = rdy[3] && valid_reg[2];
        valid_next[0] = rdy[0] ? in_valid     : valid_reg[0];
        valid_next[1] = rdy[1] ? valid_reg[0] : valid_reg[1];
        valid_next[2] = rdy[2] ? valid_reg[1] : valid_reg[2];
        valid_next[3] = rdy[3] ? valid_reg[2] : valid_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[3];

    `MCFE_ASSERT_NEXT(a_accept_fills_s0, en.s0, valid_reg[0], "accepted beat not held in stage 0")
    `MCFE_ASSERT_NEXT(a_s2_held, valid_reg[2] && !rdy[3], valid_reg[2], "stalled stage 2 beat lost")
    `MCFE_ASSERT_IMPL(a_no_overwrite, valid_reg[3] && !out_ready, !en.s3, "waiting result overwritten")

endmodule

FILE: rtl/core/mcfe_code_lane.sv
`include "motor_command_frame_encoder_macros.svh"

module mcfe_code_lane
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  mcfe_pkg::field_t                    field,
    input  mcfe_pkg::stage_en_t                 en,
    input  logic signed [mcfe_pkg::Q_W-1:0]     x,
    input  logic                                model,
    output logic [mcfe_pkg::CODE_BITS-1:0]      code
);

    mcfe_pkg::range_t rng1;
    mcfe_pkg::range_t rng2;
    mcfe_pkg::range_t rng3;

    logic signed [mcfe_pkg::Q_W-1:0]   xc;
    logic signed [mcfe_pkg::Q_W:0]     diff;
    logic [mcfe_pkg::D_W-1:0]          d_next;
    logic [mcfe_pkg::D_W-1:0]          d_reg;
    logic                              model1_reg;

    logic [mcfe_pkg::PROD_W-1:0]       prod;
    logic [mcfe_pkg::CODE_BITS-1:0]    q_est_next;
    logic [mcfe_pkg::CODE_BITS-1:0]    q_est_reg;
    logic [mcfe_pkg::N_W-1:0]          n_next;
    logic [mcfe_pkg::N_W-1:0]          n_reg;
    logic                              model2_reg;

    logic [mcfe_pkg::N_W-1:0]          qs;
    logic [mcfe_pkg::N_W-1:0]          rem;
    logic                              bump;
    logic [mcfe_pkg::CODE_BITS-1:0]    code_next;
    logic [mcfe_pkg::CODE_BITS-1:0]    code_reg;

    // stage 1: saturate and shift to a non-negative offset
    always_comb
    begin
        rng1 = mcfe_pkg::field_range(field, model);
        if (x > rng1.hi)
        begin
            xc = rng1.hi;
        end
        else if (x < rng1.lo)
        begin
            xc = rng1.lo;
        end
        else
        begin
            xc = x;
        end
        diff   = (mcfe_pkg::Q_W + 1)'(xc) - (mcfe_pkg::Q_W + 1)'(rng1.lo);
        d_next = diff[mcfe_pkg::D_W-1:0];
    end

    // stage 2: reciprocal estimate and exact numerator d * CODE_MAX
    always_comb
    begin
        rng2       = mcfe_pkg::field_range(field, model1_reg);
        prod       = mcfe_pkg::PROD_W'(d_reg) * mcfe_pkg::PROD_W'(rng2.recip);
        q_est_next = prod[mcfe_pkg::RECIP_SHIFT +: mcfe_pkg::CODE_BITS];
        n_next     = (mcfe_pkg::N_W'(d_reg) << mcfe_pkg::CODE_BITS) - mcfe_pkg::N_W'(d_reg);
    end

    // stage 3: estimate is low by at most one, fix from the remainder
    always_comb
    begin
        rng3      = mcfe_pkg::field_range(field, model2_reg);
        qs        = mcfe_pkg::N_W'(q_est_reg) * mcfe_pkg::N_W'(rng3.span);
        rem       = n_reg - qs;
        bump      = rem >= mcfe_pkg::N_W'(rng3.span);
        code_next = q_est_reg + mcfe_pkg::CODE_BITS'(bump);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            d_reg      <= d_next;
            model1_reg <= model;
        end
        if (en.s2)
        begin
            q_est_reg  <= q_est_next;
            n_reg      <= n_next;
            model2_reg <= model1_reg;
        end
        if (en.s3)
        begin
            code_reg <= code_next;
        end
    end

    assign code = code_reg;

    `MCFE_ASSERT_IMPL(a_rem_bound, en.s3, rem < (mcfe_pkg::N_W'(rng3.span) << 1), "estimate off by more than one")
    `MCFE_ASSERT_IMPL(a_no_wrap, en.s3 && bump, q_est_reg != mcfe_pkg::CODE_BITS'(mcfe_pkg::CODE_MAX), "code wrapped")

endmodule

FILE: rtl/core/motor_command_frame_encoder.sv
// motion command to extended CAN frame encoder
// s_axis: one command per beat; tdata holds angle, velocity, torque, stiffness,
//   damping (signed Q16.16) and motor id; tuser holds the model select
// m_axis: one frame per command; tdata holds the 29-bit identifier in the low
//   bits and the 64-bit big-endian payload above it
// cfg_wr_en/cfg_wr_data: command type for identifier bits 28..24, write while idle
// each value is clamped to the model range and mapped onto a 16-bit code
// the frame is valid on m_axis once the command has passed the input, offset,
//   reciprocal estimate and corrected code registers
// throughput: one command per cycle while m_axis is not stalled, set by the
//   four-register pipeline (input, offset, reciprocal estimate, corrected code)
// a stalled m_axis holds its beat; empty stages ahead of it still take beats,
//   so s_axis_tready drops only once all four stages are full
// reset clears all stages and sets the command type to 1
module motor_command_frame_encoder
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // target_angle, target_velocity, feedforward_torque, stiffness_gain,
    // damping_gain, motor_id
    input  logic [mcfe_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    // model_select
    input  logic                                   s_axis_tuser,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // frame_identifier, frame_payload, 3 zero bits
    output logic [mcfe_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic                                   cfg_wr_en,
    input  logic [mcfe_pkg::CMD_W-1:0]             cfg_wr_data
);

    mcfe_pkg::stage_en_t en;

    logic [mcfe_pkg::CMD_W-1:0]      cmd_type_reg;
    logic [mcfe_pkg::CMD_W-1:0]      cmd_out_reg;

    logic signed [mcfe_pkg::Q_W-1:0] angle_reg;
    logic signed [mcfe_pkg::Q_W-1:0] velocity_reg;
    logic signed [mcfe_pkg::Q_W-1:0] torque_reg;
    logic signed [mcfe_pkg::Q_W-1:0] kp_reg;
    logic signed [mcfe_pkg::Q_W-1:0] kd_reg;
    logic                            model_reg;
    logic [mcfe_pkg::MOTOR_ID_W-1:0] id0_reg;
    logic [mcfe_pkg::MOTOR_ID_W-1:0] id1_reg;
    logic [mcfe_pkg::MOTOR_ID_W-1:0] id2_reg;
    logic [mcfe_pkg::MOTOR_ID_W-1:0] id3_reg;

    logic [mcfe_pkg::CODE_BITS-1:0]  c_ang;
    logic [mcfe_pkg::CODE_BITS-1:0]  c_vel;
    logic [mcfe_pkg::CODE_BITS-1:0]  c_trq;
    logic [mcfe_pkg::CODE_BITS-1:0]  c_kp;
    logic [mcfe_pkg::CODE_BITS-1:0]  c_kd;

    logic [mcfe_pkg::ID_W-1:0]       frame_identifier;
    logic [mcfe_pkg::PAYLOAD_W-1:0]  frame_payload;

    mcfe_pipe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .en        (en)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_type_reg <= mcfe_pkg::CMD_TYPE_RESET;
        end
        else if (cfg_wr_en)
        begin
            cmd_type_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s0)
        begin
            angle_reg    <= s_axis_tdata[31:0];
            velocity_reg <= s_axis_tdata[63:32];
            torque_reg   <= s_axis_tdata[95:64];
            kp_reg       <= s_axis_tdata[127:96];
            kd_reg       <= s_axis_tdata[159:128];
            id0_reg      <= s_axis_tdata[167:160];
            model_reg    <= s_axis_tuser;
        end
        if (en.s1)
        begin
            id1_reg <= id0_reg;
        end
        if (en.s2)
        begin
            id2_reg <= id1_reg;
        end
        if (en.s3)
        begin
            id3_reg     <= id2_reg;
            cmd_out_reg <= cmd_type_reg;
        end
    end

    mcfe_code_lane u_lane_ang
    (
        .clk   (clk),
        .rst_n (rst_n),
        .field (mcfe_pkg::FLD_ANGLE),
        .en    (en),
        .x     (angle_reg),
        .model (model_reg),
        .code  (c_ang)
    );

    mcfe_code_lane u_lane_vel
    (
        .clk   (clk),
        .rst_n (rst_n),
        .field (mcfe_pkg::FLD_VELOCITY),
        .en    (en),
        .x     (velocity_reg),
        .model (model_reg),
        .code  (c_vel)
    );

    mcfe_code_lane u_lane_trq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .field (mcfe_pkg::FLD_TORQUE),
        .en    (en),
        .x     (torque_reg),
        .model (model_reg),
        .code  (c_trq)
    );

    mcfe_code_lane u_lane_kp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .field (mcfe_pkg::FLD_STIFFNESS),
        .en    (en),
        .x     (kp_reg),
        .model (model_reg),
        .code  (c_kp)
    );

    mcfe_code_lane u_lane_kd
    (
        .clk   (clk),
        .rst_n (rst_n),
        .field (mcfe_pkg::FLD_DAMPING),
        .en    (en),
        .x     (kd_reg),
        .model (model_reg),
        .code  (c_kd)
    );

    assign frame_identifier = {cmd_out_reg, mcfe_pkg::slot16(c_trq), id3_reg};
    assign frame_payload    = {mcfe_pkg::slot16(c_ang), mcfe_pkg::slot16(c_vel),
                               mcfe_pkg::slot16(c_kp), mcfe_pkg::slot16(c_kd)};
    assign m_axis_tdata     = {3'b000, frame_payload, frame_identifier};

endmodule
